>>> rtl/cbps_pkg.sv
// Shared types, constants and arithmetic helpers for the circle body physics step.
// Used by every module of the block; depends on nothing else.
package cbps_pkg;

  // Object store geometry.
  localparam int NUM_OBJECTS = 3;
  localparam int IDX_W       = 2;
  localparam int CNT_W       = $clog2(NUM_OBJECTS + 1);

  // Field widths.
  localparam int POS_W  = 20;
  localparam int VEL_W  = 22;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 3;

  // Shared multiplier and divider sizes.
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;
  localparam int QW     = 24;
  localparam int QUOT_W = QW + 1;
  localparam int NUM_W  = 58;
  localparam int DEN_W  = 34;
  localparam int DCNT_W = $clog2(QW + 1);

  // Reset positions in Q12.8.
  localparam logic [POS_W-1:0] CENTER_X = POS_W'(900 * 256);
  localparam logic [POS_W-1:0] CENTER_Y = POS_W'(500 * 256);
  localparam logic [POS_W-1:0] LEFT_X   = POS_W'(700 * 256);
  localparam logic [POS_W-1:0] RIGHT_X  = POS_W'(1100 * 256);

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_TIME_STEP     = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_FRICTION_KEEP = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_EDGE_MARGIN   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_FIELD_WIDTH   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_FIELD_HEIGHT  = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_CONTACT_DIST  = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_KEY_SPEED     = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_LOCAL_PLAYER  = 3'd7;

  // Key directions.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [1:0] {
    MODE_ADVANCE = 2'd0,
    MODE_LOAD    = 2'd1,
    MODE_KEY     = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_KEY, ST_BAD, ST_REPORT,
    ST_ADV_RD, ST_DMP_X, ST_DMP_Y, ST_DSP_X, ST_DSP_Y, ST_LIM, ST_LIM_WR,
    ST_CT_RD, ST_CT_SQX, ST_CT_SQY, ST_CT_CMP, ST_NOHIT,
    ST_EX_D, ST_EX_RED, ST_EX_DDX, ST_EX_DDY, ST_EX_PX, ST_EX_PY,
    ST_EX_NLO, ST_EX_NHI, ST_EX_NSUM, ST_EX_DIV, ST_HIT1, ST_HIT2
  } state_e;

  // Saturate a 26-bit signed sum to the velocity range.
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [25:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > 26'sd2097151) begin
      r = 22'sd2097151;
    end else if (v < -26'sd2097152) begin
      r = -22'sd2097152;
    end else begin
      r = v[VEL_W-1:0];
    end
    return r;
  endfunction

  // Round half up of a product divided by 2^16.
  function automatic logic signed [PROD_W-17:0] rnd16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(32768);
    return t[PROD_W-1:16];
  endfunction

  // Halve toward zero.
  function automatic logic signed [20:0] half_tz(input logic signed [20:0] v);
    logic signed [20:0] m;
    m = v[20] ? -v : v;
    m = m >>> 1;
    return v[20] ? -m : m;
  endfunction

  // Clamp a coordinate into [margin, size - margin] and then into the Q12.8 range.
  function automatic logic [POS_W-1:0] clamp_axis(input logic signed [23:0] p,
                                                  input logic [9:0] margin,
                                                  input logic [11:0] size);
    logic signed [25:0] v;
    logic signed [25:0] lo;
    logic signed [25:0] hi;
    logic signed [12:0] diff;
    diff = $signed({1'b0, size}) - $signed({3'b0, margin});
    lo   = $signed({8'b0, margin, 8'b0});
    hi   = $signed({{5{diff[12]}}, diff, 8'b0});
    v    = {{2{p[23]}}, p};
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    if (v < 26'sd0) v = 26'sd0;
    if (v > 26'sd1048575) v = 26'sd1048575;
    return v[POS_W-1:0];
  endfunction

  // Reset x position of an object.
  function automatic logic [POS_W-1:0] reset_pos_x(input int k);
    logic [POS_W-1:0] r;
    if (k == (2 % NUM_OBJECTS)) begin
      r = RIGHT_X;
    end else if (k == 1) begin
      r = LEFT_X;
    end else begin
      r = CENTER_X;
    end
    return r;
  endfunction

endpackage

>>> rtl/cbps_mul.sv
// Shared signed multiplier with a registered product.
// Uses cbps_pkg for operand widths.
module cbps_mul (
  input  logic                                 clk_i,
  input  logic signed [cbps_pkg::MUL_W-1:0]    a_i,
  input  logic signed [cbps_pkg::MUL_W-1:0]    b_i,
  output logic signed [cbps_pkg::PROD_W-1:0]   prod_o
);

  logic signed [cbps_pkg::PROD_W-1:0] prod_q;

  // One product per cycle, taken by the sequencer in the next state.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/cbps_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Uses cbps_pkg for widths; the quotient magnitude is known to fit in QW bits.
module cbps_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [cbps_pkg::NUM_W-1:0]   num_i,
  input  logic        [cbps_pkg::DEN_W-1:0]   den_i,
  output logic                                done_o,
  output logic signed [cbps_pkg::QUOT_W-1:0]  quot_o
);

  logic                              run_q;
  logic                              done_q;
  logic [cbps_pkg::DCNT_W-1:0]       cnt_q;
  logic [cbps_pkg::DEN_W-1:0]        rem_q;
  logic [cbps_pkg::QW-1:0]           low_q;
  logic [cbps_pkg::QW-1:0]           quo_q;
  logic [cbps_pkg::DEN_W-1:0]        den_q;
  logic                              neg_q;
  logic [cbps_pkg::NUM_W-1:0]        mag;
  logic [cbps_pkg::DEN_W:0]          shifted;
  logic [cbps_pkg::DEN_W+1:0]        diff;
  logic                              ge;

  // Magnitude of the dividend and one trial subtraction.
  always_comb begin
    mag     = num_i[cbps_pkg::NUM_W-1] ? cbps_pkg::NUM_W'(-num_i) : cbps_pkg::NUM_W'(num_i);
    shifted = {rem_q, low_q[cbps_pkg::QW-1]};
    diff    = {1'b0, shifted} - {2'b0, den_q};
    ge      = ~diff[cbps_pkg::DEN_W+1];
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= cbps_pkg::DCNT_W'(cbps_pkg::QW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == cbps_pkg::DCNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= mag[cbps_pkg::NUM_W-1:cbps_pkg::QW];
      low_q <= mag[cbps_pkg::QW-1:0];
      quo_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[cbps_pkg::NUM_W-1];
    end else if (run_q) begin
      rem_q <= ge ? diff[cbps_pkg::DEN_W-1:0] : shifted[cbps_pkg::DEN_W-1:0];
      low_q <= {low_q[cbps_pkg::QW-2:0], 1'b0};
      quo_q <= {quo_q[cbps_pkg::QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

>>> rtl/circle_body_physics_step.sv
// A bad index, a load, a key and an advance without contact each give one result strobe.
// A contact gives two results: with coincident centers it needs no division, else it
// mostly waits on the two divisions on the shared divider; the partner's result follows
// in the next cycle.
// busy_o drops in the cycle of the last result, so the next transfer can come at the edge
// ending it. Results cannot be stalled; reset restores the registers and object states.
module circle_body_physics_step (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 cfg_we_i,
  input  logic [cbps_pkg::CIDX_W-1:0]          cfg_idx_i,
  input  logic [cbps_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [1:0]                           mode_i,
  input  logic [1:0]                           object_i,
  input  logic [cbps_pkg::POS_W-1:0]           load_x_i,
  input  logic [cbps_pkg::POS_W-1:0]           load_y_i,
  input  logic signed [cbps_pkg::VEL_W-1:0]    load_vx_i,
  input  logic signed [cbps_pkg::VEL_W-1:0]    load_vy_i,
  input  logic [1:0]                           direction_i,
  output logic                                 valid_o,
  output logic [1:0]                           reported_object_o,
  output logic [cbps_pkg::POS_W-1:0]           pos_x_o,
  output logic [cbps_pkg::POS_W-1:0]           pos_y_o,
  output logic signed [cbps_pkg::VEL_W-1:0]    vel_x_o,
  output logic signed [cbps_pkg::VEL_W-1:0]    vel_y_o,
  output logic                                 collided_o,
  output logic                                 last_o
);

  localparam int N  = cbps_pkg::NUM_OBJECTS;
  localparam int IW = cbps_pkg::IDX_W;
  localparam int PW = cbps_pkg::POS_W;
  localparam int VW = cbps_pkg::VEL_W;
  localparam int MW = cbps_pkg::MUL_W;
  localparam int RW = cbps_pkg::PROD_W;

  // Configuration registers.
  logic [15:0] time_step_q, friction_keep_q;
  logic [9:0]  edge_margin_q, contact_distance_q;
  logic [11:0] field_width_q, field_height_q;
  logic [12:0] key_speed_q;
  logic [1:0]  local_player_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q        <= 16'd1049;
      friction_keep_q    <= 16'd64278;
      edge_margin_q      <= 10'd70;
      field_width_q      <= 12'd1800;
      field_height_q     <= 12'd1000;
      contact_distance_q <= 10'd60;
      key_speed_q        <= 13'd400;
      local_player_q     <= 2'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbps_pkg::CFG_TIME_STEP:     time_step_q        <= cfg_data_i;
        cbps_pkg::CFG_FRICTION_KEEP: friction_keep_q    <= cfg_data_i;
        cbps_pkg::CFG_EDGE_MARGIN:   edge_margin_q      <= cfg_data_i[9:0];
        cbps_pkg::CFG_FIELD_WIDTH:   field_width_q      <= cfg_data_i[11:0];
        cbps_pkg::CFG_FIELD_HEIGHT:  field_height_q     <= cfg_data_i[11:0];
        cbps_pkg::CFG_CONTACT_DIST:  contact_distance_q <= cfg_data_i[9:0];
        cbps_pkg::CFG_KEY_SPEED:     key_speed_q        <= cfg_data_i[12:0];
        cbps_pkg::CFG_LOCAL_PLAYER:  local_player_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Object store: one read port and one write port.
  logic [PW-1:0]        pos_x_q [N];
  logic [PW-1:0]        pos_y_q [N];
  logic signed [VW-1:0] vel_x_q [N];
  logic signed [VW-1:0] vel_y_q [N];

  logic [IW-1:0]        rd_idx, wr_idx;
  logic                 we_pos, we_vx, we_vy;
  logic [PW-1:0]        wd_px, wd_py, rd_px, rd_py;
  logic signed [VW-1:0] wd_vx, wd_vy, rd_vx, rd_vy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        pos_x_q[k] <= cbps_pkg::reset_pos_x(k);
        pos_y_q[k] <= cbps_pkg::CENTER_Y;
        vel_x_q[k] <= '0;
        vel_y_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < N; k++) begin
        if (wr_idx == IW'(k)) begin
          if (we_pos) begin
            pos_x_q[k] <= wd_px;
            pos_y_q[k] <= wd_py;
          end
          if (we_vx) vel_x_q[k] <= wd_vx;
          if (we_vy) vel_y_q[k] <= wd_vy;
        end
      end
    end
  end

  always_comb begin
    rd_px = '0;
    rd_py = '0;
    rd_vx = '0;
    rd_vy = '0;
    for (int k = 0; k < N; k++) begin
      if (rd_idx == IW'(k)) begin
        rd_px = pos_x_q[k];
        rd_py = pos_y_q[k];
        rd_vx = vel_x_q[k];
        rd_vy = vel_y_q[k];
      end
    end
  end

  // Sequencer and working registers.
  cbps_pkg::state_e state_q, state_d;

  logic [1:0]                    dir_q;
  logic [IW-1:0]                 i_q, rpt_q;
  logic [cbps_pkg::CNT_W-1:0]    j_q;
  logic [PW-1:0]                 ldx_q, ldy_q;
  logic signed [VW-1:0]          ldvx_q, ldvy_q;
  logic [PW-1:0]                 wpx_q, wpy_q, ox_q, oy_q;
  logic signed [VW-1:0]          wvx_q, wvy_q, ovx_q, ovy_q;
  logic signed [23:0]            cx_q, cy_q, ex_q, ey_q;
  logic signed [RW-1:0]          acc_q;
  logic [35:0]                   lim_q;
  logic signed [20:0]            dx_q, dy_q;
  logic signed [22:0]            rx_q, ry_q;
  logic [cbps_pkg::DEN_W-1:0]    dd_q;
  logic signed [40:0]            p_q;
  logic signed [cbps_pkg::QUOT_W-1:0] dlx_q, dly_q;
  logic                          ax_q;

  logic signed [MW-1:0]          mul_a, mul_b;
  logic signed [RW-1:0]          prod;
  logic                          div_start, div_done;
  logic signed [cbps_pkg::NUM_W-1:0]  div_num;
  logic signed [cbps_pkg::QUOT_W-1:0] div_quot;

  logic                          obj_ok, lp_ok, too_far, coincident, in_contact;
  logic [50:0]                   sq_sum;
  logic signed [MW-1:0]          d_sel;
  logic signed [cbps_pkg::PROD_W-17:0] rnd;

  logic                          out_ld, out_coll, out_last;
  logic [IW-1:0]                 out_idx;
  logic [PW-1:0]                 out_px, out_py;
  logic signed [VW-1:0]          out_vx, out_vy;

  logic                          valid_q, coll_q, last_q;
  logic [IW-1:0]                 oidx_q;
  logic [PW-1:0]                 opx_q, opy_q;
  logic signed [VW-1:0]          ovx_out_q, ovy_out_q;

  cbps_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  cbps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dd_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Decoded conditions.
  always_comb begin
    obj_ok     = (32'(object_i) < N);
    lp_ok      = (32'(local_player_q) < N);
    too_far    = (dx_q >= 21'sd65536) || (dx_q <= -21'sd65536) ||
                 (dy_q >= 21'sd65536) || (dy_q <= -21'sd65536);
    coincident = (dx_q == '0) && (dy_q == '0);
    sq_sum     = 51'(unsigned'(acc_q)) + 51'(unsigned'(prod));
    in_contact = (sq_sum <= {15'b0, lim_q});
    rnd        = cbps_pkg::rnd16(prod);
    d_sel      = ax_q ? MW'(dy_q) : MW'(dx_q);
    div_num    = $signed({prod[36:0], 21'b0}) + cbps_pkg::NUM_W'(acc_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbps_pkg::ST_IDLE: begin
        if (start_i) begin
          unique case (cbps_pkg::mode_e'(mode_i))
            cbps_pkg::MODE_ADVANCE: state_d = obj_ok ? cbps_pkg::ST_ADV_RD : cbps_pkg::ST_BAD;
            cbps_pkg::MODE_LOAD:    state_d = obj_ok ? cbps_pkg::ST_LOAD : cbps_pkg::ST_BAD;
            cbps_pkg::MODE_KEY:     state_d = lp_ok ? cbps_pkg::ST_KEY : cbps_pkg::ST_BAD;
            cbps_pkg::MODE_NONE:    state_d = cbps_pkg::ST_IDLE;
          endcase
        end
      end
      cbps_pkg::ST_LOAD:   state_d = cbps_pkg::ST_REPORT;
      cbps_pkg::ST_KEY:    state_d = cbps_pkg::ST_REPORT;
      cbps_pkg::ST_BAD:    state_d = cbps_pkg::ST_IDLE;
      cbps_pkg::ST_REPORT: state_d = cbps_pkg::ST_IDLE;
      cbps_pkg::ST_ADV_RD: state_d = cbps_pkg::ST_DMP_X;
      cbps_pkg::ST_DMP_X:  state_d = cbps_pkg::ST_DMP_Y;
      cbps_pkg::ST_DMP_Y:  state_d = cbps_pkg::ST_DSP_X;
      cbps_pkg::ST_DSP_X:  state_d = cbps_pkg::ST_DSP_Y;
      cbps_pkg::ST_DSP_Y:  state_d = cbps_pkg::ST_LIM;
      cbps_pkg::ST_LIM:    state_d = cbps_pkg::ST_LIM_WR;
      cbps_pkg::ST_LIM_WR: state_d = cbps_pkg::ST_CT_RD;
      cbps_pkg::ST_CT_RD: begin
        if (j_q == cbps_pkg::CNT_W'(N)) begin
          state_d = cbps_pkg::ST_NOHIT;
        end else if (j_q[IW-1:0] != i_q) begin
          state_d = cbps_pkg::ST_CT_SQX;
        end
      end
      cbps_pkg::ST_CT_SQX: state_d = cbps_pkg::ST_CT_SQY;
      cbps_pkg::ST_CT_SQY: state_d = cbps_pkg::ST_CT_CMP;
      cbps_pkg::ST_CT_CMP: state_d = in_contact ? cbps_pkg::ST_EX_D : cbps_pkg::ST_CT_RD;
      cbps_pkg::ST_NOHIT:  state_d = cbps_pkg::ST_IDLE;
      cbps_pkg::ST_EX_D:   state_d = cbps_pkg::ST_EX_RED;
      cbps_pkg::ST_EX_RED: begin
        if (!too_far) begin
          state_d = coincident ? cbps_pkg::ST_HIT1 : cbps_pkg::ST_EX_DDX;
        end
      end
      cbps_pkg::ST_EX_DDX:  state_d = cbps_pkg::ST_EX_DDY;
      cbps_pkg::ST_EX_DDY:  state_d = cbps_pkg::ST_EX_PX;
      cbps_pkg::ST_EX_PX:   state_d = cbps_pkg::ST_EX_PY;
      cbps_pkg::ST_EX_PY:   state_d = cbps_pkg::ST_EX_NLO;
      cbps_pkg::ST_EX_NLO:  state_d = cbps_pkg::ST_EX_NHI;
      cbps_pkg::ST_EX_NHI:  state_d = cbps_pkg::ST_EX_NSUM;
      cbps_pkg::ST_EX_NSUM: state_d = cbps_pkg::ST_EX_DIV;
      cbps_pkg::ST_EX_DIV: begin
        if (div_done) begin
          state_d = ax_q ? cbps_pkg::ST_HIT1 : cbps_pkg::ST_EX_NLO;
        end
      end
      cbps_pkg::ST_HIT1: state_d = cbps_pkg::ST_HIT2;
      cbps_pkg::ST_HIT2: state_d = cbps_pkg::ST_IDLE;
      default:           state_d = cbps_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: store ports, multiplier operands, divider start, result load.
  always_comb begin
    rd_idx    = rpt_q;
    wr_idx    = i_q;
    we_pos    = 1'b0;
    we_vx     = 1'b0;
    we_vy     = 1'b0;
    wd_px     = ldx_q;
    wd_py     = ldy_q;
    wd_vx     = ldvx_q;
    wd_vy     = ldvy_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    out_ld    = 1'b0;
    out_idx   = rpt_q;
    out_px    = '0;
    out_py    = '0;
    out_vx    = '0;
    out_vy    = '0;
    out_coll  = 1'b0;
    out_last  = 1'b1;
    unique case (state_q)
      cbps_pkg::ST_LOAD: begin
        we_pos = (i_q != local_player_q);
        we_vx  = (i_q != local_player_q);
        we_vy  = (i_q != local_player_q);
      end
      cbps_pkg::ST_KEY: begin
        wr_idx = local_player_q;
        wd_vx  = (dir_q == cbps_pkg::DIR_LEFT) ? -$signed({1'b0, key_speed_q, 8'b0})
                                               : $signed({1'b0, key_speed_q, 8'b0});
        wd_vy  = (dir_q == cbps_pkg::DIR_UP) ? -$signed({1'b0, key_speed_q, 8'b0})
                                             : $signed({1'b0, key_speed_q, 8'b0});
        we_vx  = (dir_q == cbps_pkg::DIR_LEFT) || (dir_q == cbps_pkg::DIR_RIGHT);
        we_vy  = (dir_q == cbps_pkg::DIR_UP) || (dir_q == cbps_pkg::DIR_DOWN);
      end
      cbps_pkg::ST_BAD: begin
        out_ld = 1'b1;
      end
      cbps_pkg::ST_REPORT: begin
        out_ld = 1'b1;
        out_px = rd_px;
        out_py = rd_py;
        out_vx = rd_vx;
        out_vy = rd_vy;
      end
      cbps_pkg::ST_ADV_RD: rd_idx = i_q;
      cbps_pkg::ST_DMP_X: begin
        mul_a = MW'(wvx_q);
        mul_b = $signed({9'b0, friction_keep_q});
      end
      cbps_pkg::ST_DMP_Y: begin
        mul_a = MW'(wvy_q);
        mul_b = $signed({9'b0, friction_keep_q});
      end
      cbps_pkg::ST_DSP_X: begin
        mul_a = MW'(wvx_q);
        mul_b = $signed({9'b0, time_step_q});
      end
      cbps_pkg::ST_DSP_Y: begin
        mul_a = MW'(wvy_q);
        mul_b = $signed({9'b0, time_step_q});
      end
      cbps_pkg::ST_LIM: begin
        mul_a = $signed({15'b0, contact_distance_q});
        mul_b = $signed({15'b0, contact_distance_q});
      end
      cbps_pkg::ST_CT_RD: rd_idx = j_q[IW-1:0];
      cbps_pkg::ST_CT_SQX: begin
        mul_a = MW'(ex_q);
        mul_b = MW'(ex_q);
      end
      cbps_pkg::ST_CT_SQY: begin
        mul_a = MW'(ey_q);
        mul_b = MW'(ey_q);
      end
      cbps_pkg::ST_NOHIT: begin
        we_pos   = 1'b1;
        we_vx    = 1'b1;
        we_vy    = 1'b1;
        wd_px    = cbps_pkg::clamp_axis(cx_q, edge_margin_q, field_width_q);
        wd_py    = cbps_pkg::clamp_axis(cy_q, edge_margin_q, field_height_q);
        wd_vx    = wvx_q;
        wd_vy    = wvy_q;
        out_ld   = 1'b1;
        out_idx  = i_q;
        out_px   = wd_px;
        out_py   = wd_py;
        out_vx   = wd_vx;
        out_vy   = wd_vy;
      end
      cbps_pkg::ST_EX_RED: begin
        mul_a = MW'(dx_q);
        mul_b = MW'(dx_q);
      end
      cbps_pkg::ST_EX_DDX: begin
        mul_a = MW'(dy_q);
        mul_b = MW'(dy_q);
      end
      cbps_pkg::ST_EX_DDY: begin
        mul_a = MW'(rx_q);
        mul_b = MW'(dx_q);
      end
      cbps_pkg::ST_EX_PX: begin
        mul_a = MW'(ry_q);
        mul_b = MW'(dy_q);
      end
      cbps_pkg::ST_EX_NLO: begin
        mul_a = $signed({4'b0, p_q[20:0]});
        mul_b = d_sel;
      end
      cbps_pkg::ST_EX_NHI: begin
        mul_a = MW'($signed(p_q[40:21]));
        mul_b = d_sel;
      end
      cbps_pkg::ST_EX_NSUM: div_start = 1'b1;
      cbps_pkg::ST_HIT1: begin
        we_pos   = 1'b1;
        we_vx    = 1'b1;
        we_vy    = 1'b1;
        wd_px    = cbps_pkg::clamp_axis($signed({4'b0, wpx_q}), edge_margin_q, field_width_q);
        wd_py    = cbps_pkg::clamp_axis($signed({4'b0, wpy_q}), edge_margin_q, field_height_q);
        wd_vx    = cbps_pkg::sat_vel(26'(wvx_q) + 26'(dlx_q));
        wd_vy    = cbps_pkg::sat_vel(26'(wvy_q) + 26'(dly_q));
        out_ld   = 1'b1;
        out_idx  = i_q;
        out_px   = wd_px;
        out_py   = wd_py;
        out_vx   = wd_vx;
        out_vy   = wd_vy;
        out_coll = 1'b1;
        out_last = 1'b0;
      end
      cbps_pkg::ST_HIT2: begin
        wr_idx   = j_q[IW-1:0];
        we_vx    = 1'b1;
        we_vy    = 1'b1;
        wd_vx    = cbps_pkg::sat_vel(26'(ovx_q) - 26'(dlx_q));
        wd_vy    = cbps_pkg::sat_vel(26'(ovy_q) - 26'(dly_q));
        out_ld   = 1'b1;
        out_idx  = j_q[IW-1:0];
        out_px   = ox_q;
        out_py   = oy_q;
        out_vx   = wd_vx;
        out_vy   = wd_vy;
        out_coll = 1'b1;
      end
      default: ;
    endcase
  end

  // State and loop control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbps_pkg::ST_IDLE;
      j_q     <= '0;
      ax_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= out_ld;
      if (state_q == cbps_pkg::ST_LIM_WR) begin
        j_q <= '0;
      end else if ((state_q == cbps_pkg::ST_CT_RD && j_q != cbps_pkg::CNT_W'(N) &&
                    j_q[IW-1:0] == i_q) ||
                   (state_q == cbps_pkg::ST_CT_CMP && !in_contact)) begin
        j_q <= j_q + 1'b1;
      end
      if (state_q == cbps_pkg::ST_EX_PY) begin
        ax_q <= 1'b0;
      end else if (state_q == cbps_pkg::ST_EX_DIV && div_done) begin
        ax_q <= 1'b1;
      end
    end
  end

  // Working data registers.
  always_ff @(posedge clk_i) begin
    if (state_q == cbps_pkg::ST_IDLE && start_i) begin
      dir_q  <= direction_i;
      i_q    <= object_i;
      rpt_q  <= (cbps_pkg::mode_e'(mode_i) == cbps_pkg::MODE_KEY) ? local_player_q : object_i;
      ldx_q  <= load_x_i;
      ldy_q  <= load_y_i;
      ldvx_q <= load_vx_i;
      ldvy_q <= load_vy_i;
    end
    unique case (state_q)
      cbps_pkg::ST_ADV_RD: begin
        wpx_q <= rd_px;
        wpy_q <= rd_py;
        wvx_q <= rd_vx;
        wvy_q <= rd_vy;
      end
      cbps_pkg::ST_DMP_Y: wvx_q <= rnd[VW-1:0];
      cbps_pkg::ST_DSP_X: wvy_q <= rnd[VW-1:0];
      cbps_pkg::ST_DSP_Y: cx_q <= $signed({4'b0, wpx_q}) + 24'($signed(rnd[22:0]));
      cbps_pkg::ST_LIM:   cy_q <= $signed({4'b0, wpy_q}) + 24'($signed(rnd[22:0]));
      cbps_pkg::ST_LIM_WR: lim_q <= {prod[19:0], 16'b0};
      cbps_pkg::ST_CT_RD: begin
        ex_q  <= cx_q - $signed({4'b0, rd_px});
        ey_q  <= cy_q - $signed({4'b0, rd_py});
        ox_q  <= rd_px;
        oy_q  <= rd_py;
        ovx_q <= rd_vx;
        ovy_q <= rd_vy;
      end
      cbps_pkg::ST_CT_SQY: acc_q <= prod;
      cbps_pkg::ST_EX_D: begin
        dx_q  <= $signed({1'b0, ox_q}) - $signed({1'b0, wpx_q});
        dy_q  <= $signed({1'b0, oy_q}) - $signed({1'b0, wpy_q});
        rx_q  <= 23'(ovx_q) - 23'(wvx_q);
        ry_q  <= 23'(ovy_q) - 23'(wvy_q);
        dlx_q <= '0;
        dly_q <= '0;
      end
      cbps_pkg::ST_EX_RED: begin
        if (too_far) begin
          dx_q <= cbps_pkg::half_tz(dx_q);
          dy_q <= cbps_pkg::half_tz(dy_q);
        end
      end
      cbps_pkg::ST_EX_DDX: acc_q <= prod;
      cbps_pkg::ST_EX_DDY: dd_q  <= acc_q[33:0] + prod[33:0];
      cbps_pkg::ST_EX_PX:  acc_q <= prod;
      cbps_pkg::ST_EX_PY:  p_q   <= acc_q[40:0] + prod[40:0];
      cbps_pkg::ST_EX_NHI: acc_q <= prod;
      cbps_pkg::ST_EX_DIV: begin
        if (div_done) begin
          if (ax_q) dly_q <= div_quot;
          else      dlx_q <= div_quot;
        end
      end
      default: ;
    endcase
  end

  // Result register: each result is shown for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q    <= 1'b0;
      last_q    <= 1'b0;
      oidx_q    <= '0;
      opx_q     <= '0;
      opy_q     <= '0;
      ovx_out_q <= '0;
      ovy_out_q <= '0;
    end else if (out_ld) begin
      coll_q    <= out_coll;
      last_q    <= out_last;
      oidx_q    <= out_idx;
      opx_q     <= out_px;
      opy_q     <= out_py;
      ovx_out_q <= out_vx;
      ovy_out_q <= out_vy;
    end
  end

  assign busy_o            = (state_q != cbps_pkg::ST_IDLE);
  assign valid_o           = valid_q;
  assign reported_object_o = oidx_q;
  assign pos_x_o           = opx_q;
  assign pos_y_o           = opy_q;
  assign vel_x_o           = ovx_out_q;
  assign vel_y_o           = ovy_out_q;
  assign collided_o        = coll_q;
  assign last_o            = last_q;

endmodule

>>> rtl/cbps_chk.sv
// Port-level checks for the circle body physics step, bound to the top level.
// Uses cbps_pkg for the mode codes.
module cbps_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] mode_i,
  input logic       valid_o,
  input logic       collided_o,
  input logic       last_o
);

  // A first contact result is always followed by the partner's result.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o && collided_o)
    else $error("contact result not followed by partner result");

  // The first result of a pair is a contact and the block is still working.
  a_pair_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> collided_o && busy_o)
    else $error("non-final result outside a contact");

  // A transfer with a real mode makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (mode_i != cbps_pkg::MODE_NONE) |=> busy_o)
    else $error("accepted item did not start work");

  // The unused mode is dropped at once.
  a_none_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (mode_i == cbps_pkg::MODE_NONE) |=> !busy_o)
    else $error("unused mode kept the block busy");

endmodule

bind circle_body_physics_step cbps_chk u_cbps_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .mode_i     (mode_i),
  .valid_o    (valid_o),
  .collided_o (collided_o),
  .last_o     (last_o)
);

>>> verif/tb_top.sv
// Self-checking testbench for the circle body physics step.
// Depends on cbps_pkg and circle_body_physics_step from the rtl folder.
module tb_top;
  import cbps_pkg::*;

  // One report of an object's state.
  typedef struct packed {
    logic [1:0]             obj;
    logic [POS_W-1:0]       px;
    logic [POS_W-1:0]       py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic                   coll;
    logic                   lst;
  } report_t;

  // Tracks the circle states and the reports they should produce.
  class physics_scoreboard;
    longint pos[NUM_OBJECTS][2];
    longint vel[NUM_OBJECTS][2];
    longint tstep, fkeep, margin, fwidth, fheight, cdist, kspeed, lplayer;
    report_t pending[$];
    int errors;

    function void clear();
      tstep = 1049; fkeep = 64278; margin = 70; fwidth = 1800; fheight = 1000;
      cdist = 60; kspeed = 400; lplayer = 1;
      for (int k = 0; k < NUM_OBJECTS; k++) begin
        pos[k][0] = reset_pos_x(k);
        pos[k][1] = 500 * 256;
        vel[k][0] = 0;
        vel[k][1] = 0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, longint v);
      case (idx)
        CFG_TIME_STEP:     tstep = v & 16'hFFFF;
        CFG_FRICTION_KEEP: fkeep = v & 16'hFFFF;
        CFG_EDGE_MARGIN:   margin = v & 10'h3FF;
        CFG_FIELD_WIDTH:   fwidth = v & 12'hFFF;
        CFG_FIELD_HEIGHT:  fheight = v & 12'hFFF;
        CFG_CONTACT_DIST:  cdist = v & 10'h3FF;
        CFG_KEY_SPEED:     kspeed = v & 13'h1FFF;
        default:           lplayer = v & 2'h3;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > 2097151) return 2097151;
      if (v < -2097152) return -2097152;
      return v;
    endfunction

    // Round half up of v / 2^16.
    function longint round16(longint v);
      longint t;
      t = v + 32768;
      if (t >= 0) return t >>> 16;
      return -((-t + 65535) >>> 16);
    endfunction

    function longint halve(longint v);
      return v >= 0 ? v >>> 1 : -((-v) >>> 1);
    endfunction

    function longint clamp(longint p, longint size);
      longint lo, hi;
      lo = margin * 256;
      hi = (size - margin) * 256;
      if (p < lo) p = lo;
      if (p > hi) p = hi;
      if (p < 0) p = 0;
      if (p > 20'hFFFFF) p = 20'hFFFFF;
      return p;
    endfunction

    function void push(int k, bit ok, bit coll, bit lst);
      report_t r;
      r.obj = k[1:0];
      r.px = ok ? pos[k][0] : 0;
      r.py = ok ? pos[k][1] : 0;
      r.vx = ok ? vel[k][0] : 0;
      r.vy = ok ? vel[k][1] : 0;
      r.coll = coll;
      r.lst = lst;
      pending.push_back(r);
    endfunction

    // Velocity swap along the normal between old centers.
    function void swap_normal(int i, int j);
      longint dx, dy, rx, ry, p, dd;
      dx = pos[j][0] - pos[i][0];
      dy = pos[j][1] - pos[i][1];
      while (dx >= 65536 || dx <= -65536 || dy >= 65536 || dy <= -65536) begin
        dx = halve(dx);
        dy = halve(dy);
      end
      dd = dx * dx + dy * dy;
      if (dd == 0) return;
      rx = vel[j][0] - vel[i][0];
      ry = vel[j][1] - vel[i][1];
      p = rx * dx + ry * dy;
      rx = (p * dx) / dd;
      ry = (p * dy) / dd;
      vel[i][0] = sat(vel[i][0] + rx);
      vel[i][1] = sat(vel[i][1] + ry);
      vel[j][0] = sat(vel[j][0] - rx);
      vel[j][1] = sat(vel[j][1] - ry);
    endfunction

    function void advance_object(int i);
      longint cx, cy, lim, ex, ey;
      int hit;
      hit = -1;
      for (int a = 0; a < 2; a++) vel[i][a] = sat(round16(vel[i][a] * fkeep));
      cx = pos[i][0] + round16(vel[i][0] * tstep);
      cy = pos[i][1] + round16(vel[i][1] * tstep);
      lim = cdist * 256 * cdist * 256;
      for (int j = 0; j < NUM_OBJECTS; j++) begin
        if (j != i && hit < 0) begin
          ex = cx - pos[j][0];
          ey = cy - pos[j][1];
          if (ex * ex + ey * ey <= lim) hit = j;
        end
      end
      if (hit >= 0) begin
        swap_normal(i, hit);
      end else begin
        pos[i][0] = cx;
        pos[i][1] = cy;
      end
      pos[i][0] = clamp(pos[i][0], fwidth);
      pos[i][1] = clamp(pos[i][1], fheight);
      if (hit < 0) begin
        push(i, 1, 0, 1);
      end else begin
        push(i, 1, 1, 0);
        push(hit, 1, 1, 1);
      end
    endfunction

    // Note an accepted input transfer.
    function void note_item(mode_e m, logic [1:0] ob, logic [POS_W-1:0] lx,
                            logic [POS_W-1:0] ly, logic signed [VEL_W-1:0] lvx,
                            logic signed [VEL_W-1:0] lvy, logic [1:0] dir);
      longint ks;
      ks = kspeed * 256;
      case (m)
        MODE_ADVANCE: begin
          if (ob >= NUM_OBJECTS) push(ob, 0, 0, 1);
          else advance_object(ob);
        end
        MODE_LOAD: begin
          if (ob >= NUM_OBJECTS) begin
            push(ob, 0, 0, 1);
          end else begin
            if (ob != lplayer) begin
              pos[ob][0] = lx;
              pos[ob][1] = ly;
              vel[ob][0] = lvx;
              vel[ob][1] = lvy;
            end
            push(ob, 1, 0, 1);
          end
        end
        MODE_KEY: begin
          if (lplayer >= NUM_OBJECTS) begin
            push(lplayer, 0, 0, 1);
          end else begin
            case (dir)
              DIR_UP:   vel[lplayer][1] = -ks;
              DIR_DOWN: vel[lplayer][1] = ks;
              DIR_LEFT: vel[lplayer][0] = -ks;
              default:  vel[lplayer][0] = ks;
            endcase
            push(lplayer, 1, 0, 1);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result transfer with the oldest expectation.
    function void check_report(report_t got);
      report_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic start_i = 0, cfg_we_i = 0;
  logic [CIDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic [1:0] mode_i = '0, object_i = '0, direction_i = '0;
  logic [POS_W-1:0] load_x_i = '0, load_y_i = '0;
  logic signed [VEL_W-1:0] load_vx_i = '0, load_vy_i = '0;
  logic busy_o, valid_o, collided_o, last_o;
  logic [1:0] reported_object_o;
  logic [POS_W-1:0] pos_x_o, pos_y_o;
  logic signed [VEL_W-1:0] vel_x_o, vel_y_o;

  physics_scoreboard board = new();
  longint cycles = 0;

  circle_body_physics_step uut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // Result monitor and watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && valid_o)
      board.check_report({reported_object_o, pos_x_o, pos_y_o, vel_x_o, vel_y_o,
                          collided_o, last_o});
    if (cycles > 1000000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  // Wait until the block has drained and nothing is expected.
  task automatic drain();
    do @(posedge clk_i); while (board.pending.size() != 0 || busy_o);
    idle_cycles(100);
  endtask

  // One register write; the enable drops again before the next write.
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    board.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  // Present one item and wait for its transfer.
  task automatic send(mode_e m, logic [1:0] ob, logic [POS_W-1:0] lx,
                      logic [POS_W-1:0] ly, logic signed [VEL_W-1:0] lvx,
                      logic signed [VEL_W-1:0] lvy, logic [1:0] dir);
    start_i <= 1;
    mode_i <= m;
    object_i <= ob;
    load_x_i <= lx;
    load_y_i <= ly;
    load_vx_i <= lvx;
    load_vy_i <= lvy;
    direction_i <= dir;
    do @(posedge clk_i); while (busy_o);
    board.note_item(m, ob, lx, ly, lvx, lvy, dir);
    start_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_random(int near);
    mode_e m;
    logic [1:0] ob;
    logic [POS_W-1:0] lx, ly;
    logic signed [VEL_W-1:0] lvx, lvy;
    int r;
    r = $urandom_range(99);
    m = r < 55 ? MODE_ADVANCE : r < 80 ? MODE_LOAD : r < 97 ? MODE_KEY : MODE_NONE;
    ob = $urandom_range(99) < 95 ? 2'($urandom_range(2)) : 2'd3;
    if (near) begin
      // Clustered loads so that contacts happen often.
      lx = 20'($urandom_range(800 * 256, 1000 * 256));
      ly = 20'($urandom_range(440 * 256, 560 * 256));
      lvx = 22'(int'($urandom_range(0, 60000)) - 30000);
      lvy = 22'(int'($urandom_range(0, 60000)) - 30000);
    end else begin
      lx = 20'($urandom);
      ly = 20'($urandom);
      lvx = 22'($urandom);
      lvy = 22'($urandom);
    end
    send(m, ob, lx, ly, lvx, lvy, 2'($urandom));
  endtask

  initial begin
    idle_cycles(6);
    rst_ni <= 1;
    idle_cycles(2);
    board.clear();

    // Directed items: every mode, bad index, field extremes.
    send(MODE_ADVANCE, 0, 0, 0, 0, 0, DIR_UP);
    send(MODE_KEY, 0, 0, 0, 0, 0, DIR_RIGHT);
    send(MODE_ADVANCE, 1, 0, 0, 0, 0, DIR_UP);
    send(MODE_LOAD, 1, 20'hFFFFF, 20'hFFFFF, 22'sh1FFFFF, 22'sh1FFFFF, DIR_UP);
    send(MODE_LOAD, 2, 20'hFFFFF, 20'hFFFFF, 22'sh1FFFFF, -22'sd2097152, DIR_UP);
    send(MODE_ADVANCE, 2, 0, 0, 0, 0, DIR_UP);
    send(MODE_LOAD, 0, 0, 0, -22'sd2097152, 22'sh1FFFFF, DIR_UP);
    send(MODE_ADVANCE, 0, 0, 0, 0, 0, DIR_UP);
    send(MODE_LOAD, 3, 0, 0, 0, 0, DIR_UP);
    send(MODE_ADVANCE, 3, 0, 0, 0, 0, DIR_UP);
    send(MODE_NONE, 0, 0, 0, 0, 0, DIR_UP);
    for (int d = 0; d < 4; d++) send(MODE_KEY, 0, 0, 0, 0, 0, 2'(d));
    // Coincident centers, then a head-on contact.
    send(MODE_LOAD, 0, 900 * 256, 500 * 256, 0, 0, DIR_UP);
    send(MODE_LOAD, 2, 900 * 256, 500 * 256, 5000, 0, DIR_UP);
    send(MODE_ADVANCE, 2, 0, 0, 0, 0, DIR_UP);
    send(MODE_LOAD, 2, 950 * 256, 520 * 256, -20000, 3000, DIR_UP);
    send(MODE_ADVANCE, 2, 0, 0, 0, 0, DIR_UP);
    send(MODE_ADVANCE, 0, 0, 0, 0, 0, DIR_UP);
    drain();

    // Phases with differing register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_TIME_STEP, 16'hFFFF); write_reg(CFG_FRICTION_KEEP, 16'hFFFF);
          write_reg(CFG_EDGE_MARGIN, 0); write_reg(CFG_FIELD_WIDTH, 12'hFFF);
          write_reg(CFG_FIELD_HEIGHT, 12'hFFF); write_reg(CFG_CONTACT_DIST, 10'h3FF);
          write_reg(CFG_KEY_SPEED, 13'h1FFF); write_reg(CFG_LOCAL_PLAYER, 0);
        end
        1: begin
          write_reg(CFG_TIME_STEP, 1); write_reg(CFG_FRICTION_KEEP, 0);
          write_reg(CFG_EDGE_MARGIN, 10'h3FF); write_reg(CFG_FIELD_WIDTH, 1);
          write_reg(CFG_FIELD_HEIGHT, 1); write_reg(CFG_CONTACT_DIST, 0);
          write_reg(CFG_KEY_SPEED, 0); write_reg(CFG_LOCAL_PLAYER, 3);
        end
        2: begin
          write_reg(CFG_TIME_STEP, 1049); write_reg(CFG_FRICTION_KEEP, 64278);
          write_reg(CFG_EDGE_MARGIN, 70); write_reg(CFG_FIELD_WIDTH, 1800);
          write_reg(CFG_FIELD_HEIGHT, 1000); write_reg(CFG_CONTACT_DIST, 60);
          write_reg(CFG_KEY_SPEED, 400); write_reg(CFG_LOCAL_PLAYER, 2);
        end
        default: begin
          for (int k = 0; k < 8; k++) write_reg(CIDX_W'(k), CFG_W'($urandom));
          write_reg(CFG_LOCAL_PLAYER, 2'($urandom_range(2)));
        end
      endcase
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(9) == 0) idle_cycles($urandom_range(1, 80));
        if (n == 120) drain();
        send_random($urandom_range(9) < 7);
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
